// ----- design/bbaq_pkg.sv -----
// Package for the 3D bounding box accumulate/query block.
// Holds the widths, request codes, lane types and the coordinate helper.
// No dependencies.
`default_nettype none

package bbaq_pkg;

	localparam int FIELD_W    = 20;
	localparam int VOL_W      = 60;
	localparam int COORD_BITS = 20;
	localparam int NUM_AXES   = 3;
	localparam int CMP_W      = COORD_BITS + 2;
	localparam int PROD2_W    = 2 * COORD_BITS;
	localparam int VOL_FULL_W = 3 * COORD_BITS;

	typedef enum logic [2:0] {
		REQ_CLEAR     = 3'd0,
		REQ_ADD_POINT = 3'd1,
		REQ_PT_QUERY  = 3'd2,
		REQ_ADD_BOX   = 3'd3,
		REQ_BOX_QUERY = 3'd4
	} req_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [CMP_W-1:0]      cmp_t;
	typedef logic [COORD_BITS-1:0]        ext_t;
	typedef logic [PROD2_W-1:0]           prod2_t;
	typedef logic [VOL_FULL_W-1:0]        vol_full_t;
	typedef logic [VOL_W-1:0]             vol_t;

	typedef struct packed {
		logic pt_in;
		logic pt_out;
		logic box_hit;
	} lane_flags_t;

	// A coordinate is the low COORD_BITS bits of its field. When the
	// coordinate is wider than the field, the field is zero extended.
	function automatic coord_t coord_of(input logic [FIELD_W-1:0] f);
		logic [COORD_BITS+FIELD_W-1:0] w;
		w = {{COORD_BITS{1'b0}}, f};
		return coord_t'(w[COORD_BITS-1:0]);
	endfunction

endpackage

`default_nettype wire

// ----- design/bbaq_lane.sv -----
// One axis lane of the bounding box: holds that axis's lower and upper
// corner, runs the point and overlap tests and reports the extent.
// Depends on bbaq_pkg.
`default_nettype none

module bbaq_lane (
	input  wire logic                 clk,
	input  wire logic                 acc,
	input  wire bbaq_pkg::req_t       req,
	input  wire logic                 has_point,
	input  wire bbaq_pkg::coord_t     p,
	input  wire bbaq_pkg::coord_t     q,
	input  wire bbaq_pkg::coord_t     e,
	output bbaq_pkg::lane_flags_t     flags,
	output bbaq_pkg::ext_t            ext
);

	bbaq_pkg::coord_t lo_q, hi_q;
	bbaq_pkg::coord_t cand_lo, cand_hi, lo_nxt, hi_nxt;
	bbaq_pkg::cmp_t   lo_w, hi_w, p_w, q_w, e_w, diff;
	bbaq_pkg::cmp_t   lo_pe, hi_me, p_pe, q_me, hi_pe, lo_me;
	logic             upd;

	always_comb begin
		lo_w  = bbaq_pkg::cmp_t'(lo_q);
		hi_w  = bbaq_pkg::cmp_t'(hi_q);
		p_w   = bbaq_pkg::cmp_t'(p);
		q_w   = bbaq_pkg::cmp_t'(q);
		e_w   = bbaq_pkg::cmp_t'(e);
		lo_pe = lo_w + e_w;
		hi_me = hi_w - e_w;
		p_pe  = p_w + e_w;
		q_me  = q_w - e_w;
		hi_pe = hi_w + e_w;
		lo_me = lo_w - e_w;

		flags.pt_in   = (lo_pe <= p_w) && (p_w <= hi_me);
		flags.pt_out  = (p_w > hi_pe) || (p_w < lo_me);
		// Four-way endpoint test: either end of one interval lies within
		// the other, each interval shrunk by the margin.
		flags.box_hit = ((lo_pe <= p_w) && (p_w <= hi_me)) ||
		                ((lo_pe <= q_w) && (q_w <= hi_me)) ||
		                ((p_pe <= lo_w) && (lo_w <= q_me)) ||
		                ((p_pe <= hi_w) && (hi_w <= q_me));

		diff = hi_w - lo_w;
		ext  = diff[bbaq_pkg::COORD_BITS-1:0];
	end

	// Including a box is including its two corners, so the candidate
	// interval is the ordered pair of p and q.
	always_comb begin
		upd = 1'b0;
		cand_lo = p;
		cand_hi = p;
		case (req)
			bbaq_pkg::REQ_ADD_POINT: begin
				upd = acc;
			end
			bbaq_pkg::REQ_ADD_BOX: begin
				upd = acc;
				if (q < p) begin
					cand_lo = q;
				end else begin
					cand_hi = q;
				end
			end
			default: begin
				upd = 1'b0;
			end
		endcase
		if (!has_point) begin
			lo_nxt = cand_lo;
			hi_nxt = cand_hi;
		end else begin
			lo_nxt = (cand_lo < lo_q) ? cand_lo : lo_q;
			hi_nxt = (cand_hi > hi_q) ? cand_hi : hi_q;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			lo_q <= lo_nxt;
			hi_q <= hi_nxt;
		end
	end

endmodule

`default_nettype wire

// ----- design/bbaq_merge.sv -----
// Merge stage: combines the lane flags into the query answers and forms
// the box volume through a registered multiplier chain.
// Depends on bbaq_pkg.
`default_nettype none

module bbaq_merge (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         adv,
	input  wire logic                                         acc,
	input  wire bbaq_pkg::req_t                               req,
	input  wire logic                                         has_point,
	input  wire logic                                         has_point_nxt,
	input  wire bbaq_pkg::lane_flags_t [bbaq_pkg::NUM_AXES-1:0] flags,
	input  wire bbaq_pkg::ext_t [bbaq_pkg::NUM_AXES-1:0]        ext,
	output logic                                              out_valid,
	output logic                                              inside_res,
	output logic                                              outside,
	output bbaq_pkg::vol_t                                    box_volume,
	output logic                                              box_nonempty
);

	localparam int CB = bbaq_pkg::COORD_BITS;

	logic all_in, any_out, any_miss, ins, outs;

	logic vld_s1, vld_s2, vld_s3;
	logic ins_s1, outs_s1, ne_s1;
	logic ins_s2, outs_s2, ne_s2;
	logic ins_s3, outs_s3, ne_s3;
	bbaq_pkg::prod2_t prod01_s2, pp_lo_s3, pp_hi_s3;
	bbaq_pkg::ext_t   ext2_s2;

	bbaq_pkg::vol_full_t                       vol_sum;
	logic [bbaq_pkg::VOL_FULL_W+bbaq_pkg::VOL_W-1:0] vol_wide;

	always_comb begin
		all_in   = 1'b1;
		any_out  = 1'b0;
		any_miss = 1'b0;
		for (int a = 0; a < bbaq_pkg::NUM_AXES; a++) begin
			all_in   = all_in & flags[a].pt_in;
			any_out  = any_out | flags[a].pt_out;
			any_miss = any_miss | ~flags[a].box_hit;
		end
		ins  = 1'b0;
		outs = 1'b0;
		case (req)
			bbaq_pkg::REQ_PT_QUERY: begin
				ins  = has_point & all_in;
				outs = ~has_point | any_out;
			end
			bbaq_pkg::REQ_BOX_QUERY: begin
				outs = ~has_point | any_miss;
			end
			default: begin
				ins  = 1'b0;
				outs = 1'b0;
			end
		endcase
	end

	always_comb begin
		vol_sum  = bbaq_pkg::vol_full_t'(pp_lo_s3) +
		           (bbaq_pkg::vol_full_t'(pp_hi_s3) << CB);
		vol_wide = {{bbaq_pkg::VOL_W{1'b0}}, vol_sum};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1    <= acc;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			out_valid <= vld_s3;
		end
	end

	// The lane extents are read while the item sits in s1, after the
	// corners took its update and before any later item can change them.
	always_ff @(posedge clk) begin
		if (adv) begin
			ins_s1  <= ins;
			outs_s1 <= outs;
			ne_s1   <= has_point_nxt;

			ins_s2    <= ins_s1;
			outs_s2   <= outs_s1;
			ne_s2     <= ne_s1;
			prod01_s2 <= bbaq_pkg::prod2_t'(ext[0]) * bbaq_pkg::prod2_t'(ext[1]);
			ext2_s2   <= ext[2];

			ins_s3   <= ins_s2;
			outs_s3  <= outs_s2;
			ne_s3    <= ne_s2;
			pp_lo_s3 <= bbaq_pkg::prod2_t'(prod01_s2[CB-1:0]) *
			            bbaq_pkg::prod2_t'(ext2_s2);
			pp_hi_s3 <= bbaq_pkg::prod2_t'(prod01_s2[2*CB-1:CB]) *
			            bbaq_pkg::prod2_t'(ext2_s2);

			inside_res   <= ins_s3;
			outside      <= outs_s3;
			box_nonempty <= ne_s3;
			box_volume   <= ne_s3 ? vol_wide[bbaq_pkg::VOL_W-1:0] : '0;
		end
	end

endmodule

`default_nettype wire

// ----- design/bounding_box_accumulate_query.sv -----
// Top level of the 3D axis-aligned bounding box accumulate/query block.
// Instantiates three bbaq_lane axis lanes and the bbaq_merge stage.
// Depends on bbaq_pkg, bbaq_lane and bbaq_merge.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   input   | in_valid / in_ready  | req_type, px..pz, qx..qz, margin
//   output  | out_valid / out_ready| inside_res, outside, box_volume,
//           |                      | box_nonempty
//
// One item is taken per cycle while the output is not stalled; its result
// passes stages s1, s2 and s3 to the output register: one stage reads the
// updated extents, two more form the volume product.
// The corners update at the edge that takes the item, so the next item sees
// them at once. The whole pipeline holds when the output register is full
// and not taken; in_ready is low in exactly those cycles.
// Reset clears the box flag and the pipeline valid bits; the corners need
// no reset.
`default_nettype none

module bounding_box_accumulate_query (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [2:0]                          req_type,
	input  wire logic signed [bbaq_pkg::FIELD_W-1:0] px,
	input  wire logic signed [bbaq_pkg::FIELD_W-1:0] py,
	input  wire logic signed [bbaq_pkg::FIELD_W-1:0] pz,
	input  wire logic signed [bbaq_pkg::FIELD_W-1:0] qx,
	input  wire logic signed [bbaq_pkg::FIELD_W-1:0] qy,
	input  wire logic signed [bbaq_pkg::FIELD_W-1:0] qz,
	input  wire logic signed [bbaq_pkg::FIELD_W-1:0] margin,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     inside_res,
	output logic                                     outside,
	output logic [bbaq_pkg::VOL_W-1:0]               box_volume,
	output logic                                     box_nonempty
);

	logic                  adv, acc, has_point_q, has_point_nxt;
	bbaq_pkg::req_t        req;
	bbaq_pkg::coord_t      e_c;
	bbaq_pkg::coord_t [bbaq_pkg::NUM_AXES-1:0]      p_c, q_c;
	bbaq_pkg::lane_flags_t [bbaq_pkg::NUM_AXES-1:0] flags;
	bbaq_pkg::ext_t [bbaq_pkg::NUM_AXES-1:0]        ext;

	assign adv      = ~out_valid | out_ready;
	assign in_ready = adv;
	assign acc      = in_valid & adv;
	assign req      = bbaq_pkg::req_t'(req_type);

	assign p_c[0] = bbaq_pkg::coord_of(px);
	assign p_c[1] = bbaq_pkg::coord_of(py);
	assign p_c[2] = bbaq_pkg::coord_of(pz);
	assign q_c[0] = bbaq_pkg::coord_of(qx);
	assign q_c[1] = bbaq_pkg::coord_of(qy);
	assign q_c[2] = bbaq_pkg::coord_of(qz);
	assign e_c    = bbaq_pkg::coord_of(margin);

	always_comb begin
		case (req)
			bbaq_pkg::REQ_CLEAR:     has_point_nxt = 1'b0;
			bbaq_pkg::REQ_ADD_POINT: has_point_nxt = 1'b1;
			bbaq_pkg::REQ_ADD_BOX:   has_point_nxt = 1'b1;
			default:                 has_point_nxt = has_point_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_point_q <= 1'b0;
		end else if (acc) begin
			has_point_q <= has_point_nxt;
		end
	end

	for (genvar a = 0; a < bbaq_pkg::NUM_AXES; a++) begin : g_lane
		bbaq_lane u_lane (
			.clk       (clk),
			.acc       (acc),
			.req       (req),
			.has_point (has_point_q),
			.p         (p_c[a]),
			.q         (q_c[a]),
			.e         (e_c),
			.flags     (flags[a]),
			.ext       (ext[a])
		);
	end

	bbaq_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.acc           (acc),
		.req           (req),
		.has_point     (has_point_q),
		.has_point_nxt (has_point_nxt),
		.flags         (flags),
		.ext           (ext),
		.out_valid     (out_valid),
		.inside_res    (inside_res),
		.outside       (outside),
		.box_volume    (box_volume),
		.box_nonempty  (box_nonempty)
	);

`ifndef SYNTHESIS
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(box_volume) &&
			$stable(inside_res) && $stable(outside) && $stable(box_nonempty)))
		else $error("stalled result changed before it was taken");

	a_empty_volume: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !box_nonempty) |-> (box_volume == '0))
		else $error("empty box reports a nonzero volume");

	a_inside_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && inside_res) |-> box_nonempty)
		else $error("point reported inside an empty box");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req == bbaq_pkg::REQ_CLEAR) |=> !has_point_q)
		else $error("clear item left the box flag set");
`endif

endmodule

`default_nettype wire
